@@ rtl/tsv_pkg.sv @@
`default_nettype none
package tsv_pkg;

  // Input command codes
  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_NOTE_ON  = 3'd1,
    CMD_NOTE_OFF = 3'd2,
    CMD_TRIGGER  = 3'd3,
    CMD_FADE     = 3'd4,
    CMD_HALT     = 3'd5,
    CMD_LOAD     = 3'd6,
    CMD_NOP      = 3'd7
  } cmd_e;

  // Voice states
  typedef enum logic [1:0] {
    V_IDLE = 2'd0,
    V_PLAY = 2'd1,
    V_FADE = 2'd2
  } voice_e;

  // Tick sequencer states
  typedef enum logic [2:0] {
    SEQ_IDLE  = 3'd0,
    SEQ_GAIN  = 3'd1,
    SEQ_LEFT  = 3'd2,
    SEQ_RIGHT = 3'd3,
    SEQ_DONE  = 3'd4
  } seq_e;

  // Configuration port geometry and register indexes
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_NOTE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_LEN  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 4'd7;

  // Mode flag bit positions
  localparam int unsigned MODE_LOOP    = 0;
  localparam int unsigned MODE_OFFSTOP = 1;
  localparam int unsigned MODE_RETRIG  = 2;

  // Fade level constants, Q1.15
  localparam logic [16:0] LEVEL_ONE = 17'd32768;
  localparam logic [16:0] LEVEL_END = 17'd3;

  // Multiplier geometry
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Round magnitude product >> 29 to nearest (ties away), apply sign, saturate
  function automatic logic [15:0] round_sat(input logic [MUL_P_W-1:0] prod,
                                            input logic neg);
    logic [MUL_P_W:0] sum;
    logic [19:0]      r;
    logic [15:0]      mag;
    sum = {1'b0, prod} + (MUL_P_W+1)'(29'h1000_0000);
    r   = sum[MUL_P_W:29] ;
    if (neg) begin
      mag = (r > 20'd32768) ? 16'h8000 : r[15:0];
      return 16'(~mag + 16'd1);
    end
    return (r > 20'd32767) ? 16'h7FFF : r[15:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/tsv_if.sv @@
`default_nettype none
// Command channel
interface tsv_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [6:0]  note;
  logic [6:0]  velocity;
  logic [15:0] load_address;
  logic signed [15:0] left_in;
  logic signed [15:0] right_in;

  modport source (output valid, cmd, note, velocity, load_address, left_in, right_in,
                  input ready);
  modport sink   (input valid, cmd, note, velocity, load_address, left_in, right_in,
                  output ready);
endinterface

// Result channel
interface tsv_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  logic        playing;
  logic [16:0] position;

  modport source (output valid, left_out, right_out, playing, position, input ready);
  modport sink   (input valid, left_out, right_out, playing, position, output ready);
endinterface
`default_nettype wire

@@ rtl/tsv_store.sv @@
`default_nettype none
// Stereo sample memory: one write port, one registered read port
module tsv_store #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [31:0]   wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/tsv_mul.sv @@
`default_nettype none
// Shared unsigned multiplier with registered product
module tsv_mul
  import tsv_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [MUL_A_W-1:0] a_i,
  input  wire logic [MUL_B_W-1:0] b_i,
  output logic      [MUL_P_W-1:0] prod_o
);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
    end
  end

endmodule
`default_nettype wire

@@ rtl/triggered_sample_voice_core.sv @@
`default_nettype none
// One-shot stereo sample voice with a linear fade. Every command except a tick of a
// playing voice is handled in the cycle it is accepted and returns its result beat on
// the next cycle. A tick of a playing voice goes through the tick sequencer from accept to result:
// the fade and position update and the store read happen at the accept edge, then
// three passes go through one shared 32x16 multiplier (fade level times gain, then the
// left and right sample magnitudes times that product), with rounding and saturation
// behind the last two, and the last cycle loads the result register.
// The command channel is ready only while the tick sequencer is idle and the result
// register is empty or being drained. The sample store has no reset; only loaded words
// may be played.
module triggered_sample_voice_core
  import tsv_pkg::*;
#(
  parameter int unsigned SAMPLE_DEPTH = 65536
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  tsv_in_if.sink                     in_i,
  tsv_out_if.source                  out_o
);

  localparam int unsigned AW = $clog2(SAMPLE_DEPTH);

  // Configuration registers
  logic [2:0]  mode_q;
  logic [7:0]  trig_q;
  logic [15:0] offs_q;
  logic [16:0] slen_q;
  logic [15:0] fin_q;
  logic [15:0] fout_q;
  logic [16:0] fol_q;
  logic [15:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 3'd4;
      trig_q <= 8'd128;
      offs_q <= 16'd0;
      slen_q <= 17'd0;
      fin_q  <= 16'd228;
      fout_q <= 16'd85;
      fol_q  <= 17'd384;
      gain_q <= 16'd16384;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:      mode_q <= cfg_data_i[2:0];
        CFG_TRIG_NOTE: trig_q <= cfg_data_i[7:0];
        CFG_OFFSET:    offs_q <= cfg_data_i[15:0];
        CFG_LENGTH:    slen_q <= cfg_data_i;
        CFG_FADE_IN:   fin_q  <= cfg_data_i[15:0];
        CFG_FADE_OUT:  fout_q <= cfg_data_i[15:0];
        CFG_FADE_LEN:  fol_q  <= cfg_data_i;
        CFG_GAIN:      gain_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Voice state
  voice_e      voice_q, voice_d;
  logic [16:0] pos_q, pos_d;
  logic [15:0] level_q, level_d;
  logic        tgt_q, tgt_d;
  logic        zero_q, zero_d;

  // Sequencer and result register
  seq_e        seq_q, seq_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_l_q, out_l_d, out_r_q, out_r_d;
  logic        out_play_q, out_play_d;
  logic [16:0] out_pos_q, out_pos_d;
  logic [15:0] left_res_q;
  logic [31:0] lg_q;

  // Derived lengths and matching
  logic [16:0] len, lim, offs_eff;
  logic        len_nz, match, accept, tick_go;
  cmd_e        cmd;

  assign len      = (32'(slen_q) > SAMPLE_DEPTH) ? 17'(SAMPLE_DEPTH) : slen_q;
  assign len_nz   = (len != 17'd0);
  assign lim      = len_nz ? (len - 17'd1) : 17'd0;
  assign offs_eff = ({1'b0, offs_q} > lim) ? lim : {1'b0, offs_q};
  assign match    = trig_q[7] || ({1'b0, in_i.note} == trig_q);
  assign cmd      = cmd_e'(in_i.cmd);

  assign in_i.ready = (seq_q == SEQ_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  // Command decode and tick state update
  always_comb begin
    voice_e      v1;
    logic        t1;
    logic [16:0] target, in_s, out_s, lvl, lvl_n, p1, pn;
    voice_d = voice_q;
    pos_d   = pos_q;
    level_d = level_q;
    tgt_d   = tgt_q;
    zero_d  = zero_q;
    tick_go = 1'b0;
    v1      = voice_q;
    t1      = tgt_q;
    target  = 17'd0;
    in_s    = (fin_q == 16'd0) ? 17'd1 : {1'b0, fin_q};
    out_s   = (fout_q == 16'd0) ? 17'd1 : {1'b0, fout_q};
    lvl     = {1'b0, level_q};
    lvl_n   = lvl;
    p1      = pos_q + 17'd1;
    pn      = p1;
    if (accept && cmd != CMD_LOAD && cmd != CMD_NOP) begin
      if (!len_nz) begin
        voice_d = V_IDLE;
      end else begin
        unique case (cmd)
          CMD_TICK: begin
            if (voice_q != V_IDLE) begin
              tick_go = 1'b1;
              // pre-emptive fade before the end when not looping
              if (voice_q == V_PLAY && !mode_q[MODE_LOOP] &&
                  ({1'b0, pos_q} + {1'b0, fol_q}) >= {1'b0, len}) begin
                v1 = V_FADE;
                t1 = 1'b0;
              end
              target = t1 ? LEVEL_ONE : 17'd0;
              if (lvl < target) begin
                lvl_n = ((target - lvl) <= in_s) ? target : (lvl + in_s);
              end else if (lvl > target) begin
                lvl_n = ((lvl - target) <= out_s) ? target : (lvl - out_s);
              end
              zero_d = !(pos_q < len);
              if (p1 >= len) begin
                if (mode_q[MODE_LOOP]) begin
                  pn = offs_eff;
                end else begin
                  v1 = V_IDLE;
                end
              end
              if (v1 == V_FADE && lvl_n <= LEVEL_END) begin
                v1 = V_IDLE;
              end
              voice_d = v1;
              tgt_d   = t1;
              level_d = lvl_n[15:0];
              pos_d   = pn;
            end
          end
          CMD_NOTE_ON: begin
            if (in_i.velocity != 7'd0) begin
              if (match && (voice_q == V_IDLE || mode_q[MODE_RETRIG])) begin
                voice_d = V_PLAY;
                pos_d   = offs_eff;
                level_d = 16'd0;
                tgt_d   = 1'b1;
              end
            end else if (match && mode_q[MODE_OFFSTOP] && voice_q != V_IDLE) begin
              voice_d = V_FADE;
              tgt_d   = 1'b0;
            end
          end
          CMD_NOTE_OFF: begin
            if (match && mode_q[MODE_OFFSTOP] && voice_q != V_IDLE) begin
              voice_d = V_FADE;
              tgt_d   = 1'b0;
            end
          end
          CMD_TRIGGER: begin
            voice_d = V_PLAY;
            pos_d   = offs_eff;
            level_d = 16'd0;
            tgt_d   = 1'b1;
          end
          CMD_FADE: begin
            if (voice_q != V_IDLE) begin
              voice_d = V_FADE;
              tgt_d   = 1'b0;
            end
          end
          CMD_HALT: voice_d = V_IDLE;
          CMD_LOAD, CMD_NOP: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_q <= V_IDLE;
      pos_q   <= 17'd0;
      level_q <= 16'd0;
      tgt_q   <= 1'b0;
      zero_q  <= 1'b0;
    end else begin
      voice_q <= voice_d;
      pos_q   <= pos_d;
      level_q <= level_d;
      tgt_q   <= tgt_d;
      zero_q  <= zero_d;
    end
  end

  // Sample store
  logic        st_we;
  logic [31:0] rdata;

  assign st_we = accept && (cmd == CMD_LOAD) && (32'(in_i.load_address) < SAMPLE_DEPTH);

  tsv_store #(
    .DEPTH (SAMPLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (AW'(in_i.load_address)),
    .wdata_i ({in_i.right_in, in_i.left_in}),
    .re_i    (tick_go && !zero_d),
    .raddr_i (AW'(pos_q)),
    .rdata_o (rdata)
  );

  // Sample magnitudes and signs
  logic [15:0] wl, wr, mag_l, mag_r;

  assign wl    = zero_q ? 16'd0 : rdata[15:0];
  assign wr    = zero_q ? 16'd0 : rdata[31:16];
  assign mag_l = wl[15] ? 16'(~wl + 16'd1) : wl;
  assign mag_r = wr[15] ? 16'(~wr + 16'd1) : wr;

  // Shared multiplier
  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;

  tsv_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Sequencer next state
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SEQ_IDLE:  if (tick_go) seq_d = SEQ_GAIN;
      SEQ_GAIN:  seq_d = SEQ_LEFT;
      SEQ_LEFT:  seq_d = SEQ_RIGHT;
      SEQ_RIGHT: seq_d = SEQ_DONE;
      SEQ_DONE:  seq_d = SEQ_IDLE;
      default:   seq_d = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operands
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (seq_q)
      SEQ_GAIN: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(level_q);
        mul_b  = gain_q;
      end
      SEQ_LEFT: begin
        mul_en = 1'b1;
        mul_a  = prod[MUL_A_W-1:0];
        mul_b  = mag_l;
      end
      SEQ_RIGHT: begin
        mul_en = 1'b1;
        mul_a  = lg_q;
        mul_b  = mag_r;
      end
      SEQ_IDLE, SEQ_DONE: ;
      default: ;
    endcase
  end

  // Intermediate products
  always_ff @(posedge clk_i) begin
    if (seq_q == SEQ_LEFT) begin
      lg_q <= prod[31:0];
    end
    if (seq_q == SEQ_RIGHT) begin
      left_res_q <= round_sat(prod, wl[15]);
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_l_d     = out_l_q;
    out_r_d     = out_r_q;
    out_play_d  = out_play_q;
    out_pos_d   = out_pos_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (seq_q == SEQ_DONE) begin
      out_valid_d = 1'b1;
      out_l_d     = left_res_q;
      out_r_d     = round_sat(prod, wr[15]);
      out_play_d  = (voice_q != V_IDLE);
      out_pos_d   = pos_q;
    end else if (accept && !tick_go) begin
      out_valid_d = 1'b1;
      out_l_d     = 16'd0;
      out_r_d     = 16'd0;
      out_play_d  = (voice_d != V_IDLE);
      out_pos_d   = pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_l_q    <= out_l_d;
    out_r_q    <= out_r_d;
    out_play_q <= out_play_d;
    out_pos_q  <= out_pos_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = out_l_q;
  assign out_o.right_out = out_r_q;
  assign out_o.playing   = out_play_q;
  assign out_o.position  = out_pos_q;

  // Checks
  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q != SEQ_IDLE) |-> !out_valid_q)
    else $error("result beat pending while tick sequencer busy");

  a_done_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_DONE) |=> out_valid_q)
    else $error("tick finished without a result beat");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, level_q} <= LEVEL_ONE))
    else $error("fade level above unity");

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none
module tb_top
  import tsv_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VOICE_DEPTH = 65536;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  // One command beat and one result beat
  typedef struct packed {
    cmd_e        cmd;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [15:0] addr;
    logic [15:0] left;
    logic [15:0] right;
  } voice_cmd_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        playing;
    logic [16:0] position;
  } voice_result_t;

  // One full register setting
  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  trig;
    logic [15:0] offset;
    logic [16:0] len;
    logic [15:0] fin;
    logic [15:0] fout;
    logic [16:0] flen;
    logic [15:0] gain;
  } voice_setup_t;

  // Mirror of the voice: registers, state, store and the results it owes
  class voice_mirror;
    logic [2:0]  mode;
    logic [7:0]  trig;
    logic [15:0] offset;
    logic [16:0] slen;
    logic [15:0] fin;
    logic [15:0] fout;
    logic [16:0] flen;
    logic [15:0] gain;

    voice_e      vstate;
    int unsigned pos;
    int unsigned level;
    bit          target_high;
    logic [31:0] store [VOICE_DEPTH];

    voice_result_t results_due[$];
    int unsigned   errors;
    int unsigned   checked;

    function new();
      mode = 3'd4; trig = 8'd128; offset = '0; slen = '0;
      fin = 16'd228; fout = 16'd85; flen = 17'd384; gain = 16'd16384;
      vstate = V_IDLE; pos = 0; level = 0; target_high = 1'b0;
      errors = 0; checked = 0;
    endfunction

    function void cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_MODE:      mode   = v[2:0];
        CFG_TRIG_NOTE: trig   = v[7:0];
        CFG_OFFSET:    offset = v[15:0];
        CFG_LENGTH:    slen   = v[16:0];
        CFG_FADE_IN:   fin    = v[15:0];
        CFG_FADE_OUT:  fout   = v[15:0];
        CFG_FADE_LEN:  flen   = v[16:0];
        CFG_GAIN:      gain   = v[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_len();
      return (slen > VOICE_DEPTH) ? VOICE_DEPTH : slen;
    endfunction

    // Start offset, clamped to the last valid word
    function int unsigned start_pos(int unsigned len);
      int unsigned lim;
      lim = (len > 0) ? len - 1 : 0;
      return (offset > lim) ? lim : offset;
    endfunction

    function void start_voice(int unsigned len);
      pos = start_pos(len);
      vstate = V_PLAY;
      level = 0;
      target_high = 1'b1;
    endfunction

    function void fade_voice();
      if (vstate != V_IDLE) begin
        vstate = V_FADE;
        target_high = 1'b0;
      end
    endfunction

    // Sign-magnitude scale by level and gain, round half away, saturate
    function logic [15:0] scale(logic [15:0] raw, int unsigned lvl, logic [15:0] g);
      longint unsigned mag, prod, r;
      bit neg;
      neg  = raw[15];
      mag  = neg ? (64'h10000 - {48'd0, raw}) : {48'd0, raw};
      prod = mag * lvl * g;
      r    = (prod + 64'd268435456) >> 29;
      if (neg) begin
        if (r > 32768) r = 32768;
        return 16'(64'h10000 - r);
      end
      if (r > 32767) r = 32767;
      return r[15:0];
    endfunction

    function void tick_voice(int unsigned len, output logic [15:0] l, output logic [15:0] r);
      int unsigned tgt, ins, outs;
      logic [31:0] word;
      l = '0;
      r = '0;
      if (vstate == V_IDLE) return;
      // early fade-out near the end of a one-shot
      if (vstate == V_PLAY && !mode[MODE_LOOP] &&
          longint'(pos) >= longint'(len) - longint'(flen)) begin
        vstate = V_FADE;
        target_high = 1'b0;
      end
      tgt  = target_high ? LEVEL_ONE : 0;
      ins  = (fin != 0) ? fin : 1;
      outs = (fout != 0) ? fout : 1;
      if (level < tgt)
        level = (tgt - level <= ins) ? tgt : level + ins;
      else if (level > tgt)
        level = (level - tgt <= outs) ? tgt : level - outs;
      word = (pos < len) ? store[pos] : '0;
      l = scale(word[15:0], level, gain);
      r = scale(word[31:16], level, gain);
      pos++;
      if (pos >= len) begin
        if (mode[MODE_LOOP]) pos = start_pos(len);
        else vstate = V_IDLE;
      end
      if (vstate == V_FADE && level <= LEVEL_END) vstate = V_IDLE;
    endfunction

    // Predict the result of one accepted command beat
    function void accept_command(voice_cmd_t c);
      int unsigned   len;
      bit            hit;
      logic [15:0]   l, r;
      voice_result_t res;
      len = eff_len();
      l = '0;
      r = '0;
      hit = trig[7] || ({1'b0, c.note} == trig);
      if (c.cmd == CMD_LOAD) begin
        store[c.addr] = {c.right, c.left};
      end else if (c.cmd == CMD_NOP) begin
        // status only
      end else if (len == 0) begin
        vstate = V_IDLE;
      end else begin
        case (c.cmd)
          CMD_TICK: tick_voice(len, l, r);
          CMD_NOTE_ON: begin
            if (c.velocity != 0) begin
              if (hit && (vstate == V_IDLE || mode[MODE_RETRIG])) start_voice(len);
            end else if (hit && mode[MODE_OFFSTOP]) begin
              fade_voice();
            end
          end
          CMD_NOTE_OFF: if (hit && mode[MODE_OFFSTOP]) fade_voice();
          CMD_TRIGGER:  start_voice(len);
          CMD_FADE:     fade_voice();
          default:      vstate = V_IDLE;
        endcase
      end
      res.left     = l;
      res.right    = r;
      res.playing  = (vstate != V_IDLE);
      res.position = pos[16:0];
      results_due.push_back(res);
    endfunction

    // Compare one result beat against the oldest prediction
    function void match_result(voice_result_t got, time t);
      voice_result_t exp_r;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: result with none due: L=%0d R=%0d play=%0b pos=%0d", t,
                 $signed(got.left), $signed(got.right), got.playing, got.position);
        return;
      end
      exp_r = results_due.pop_front();
      checked++;
      if (got !== exp_r) begin
        errors++;
        $display("%0t: mismatch expected L=%0d R=%0d play=%0b pos=%0d, got L=%0d R=%0d play=%0b pos=%0d",
                 t, $signed(exp_r.left), $signed(exp_r.right), exp_r.playing, exp_r.position,
                 $signed(got.left), $signed(got.right), got.playing, got.position);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  tsv_in_if  cmd_if ();
  tsv_out_if res_if ();

  triggered_sample_voice_core #(
    .SAMPLE_DEPTH(VOICE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (cmd_if),
    .out_o      (res_if)
  );

  voice_mirror mirror = new();
  bit          loaded [VOICE_DEPTH];
  bit          calm = 1'b0;
  int unsigned cycles = 0;
  int unsigned n_cmds = 0, n_ticks = 0, n_loads = 0, n_setups = 0;

  always #4 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles", $time, cycles);
      $display("tb_top failed");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin : res_mon
    voice_result_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.left     = res_if.left_out;
      got.right    = res_if.right_out;
      got.playing  = res_if.playing;
      got.position = res_if.position;
      mirror.match_result(got, $time);
    end
  end

  // Result side back-pressure in bursts
  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      if (!calm) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
    end
  end

  function automatic voice_cmd_t mk_cmd(cmd_e op, logic [6:0] nt, logic [6:0] vel);
    voice_cmd_t c;
    c.cmd      = op;
    c.note     = nt;
    c.velocity = vel;
    c.addr     = 16'($urandom);
    c.left     = 16'($urandom);
    c.right    = 16'($urandom);
    return c;
  endfunction

  function automatic voice_cmd_t load_cmd(logic [15:0] a, logic [15:0] l, logic [15:0] r);
    voice_cmd_t c;
    c = mk_cmd(CMD_LOAD, 7'($urandom), 7'($urandom));
    c.addr  = a;
    c.left  = l;
    c.right = r;
    return c;
  endfunction

  // Random command, biased toward starting an idle voice and ticking it
  function automatic voice_cmd_t rand_cmd();
    voice_cmd_t  c;
    int unsigned pick;
    c = mk_cmd(CMD_TICK, 7'($urandom), 7'($urandom));
    pick = $urandom_range(0, 99);
    if (mirror.vstate == V_IDLE && pick < 40) c.cmd = (pick < 20) ? CMD_TRIGGER : CMD_NOTE_ON;
    else if (pick < 55) c.cmd = CMD_TICK;
    else if (pick < 65) c.cmd = CMD_NOTE_ON;
    else if (pick < 72) c.cmd = CMD_NOTE_OFF;
    else if (pick < 78) c.cmd = CMD_TRIGGER;
    else if (pick < 84) c.cmd = CMD_FADE;
    else if (pick < 88) c.cmd = CMD_HALT;
    else if (pick < 96) c.cmd = CMD_LOAD;
    else c.cmd = CMD_NOP;
    if (c.cmd == CMD_NOTE_ON || c.cmd == CMD_NOTE_OFF) begin
      if (!mirror.trig[7] && $urandom_range(0, 3) != 0) c.note = mirror.trig[6:0];
    end
    if (c.cmd == CMD_NOTE_ON) begin
      if (mirror.vstate == V_IDLE && pick < 40 && c.velocity == 0) c.velocity = 7'd1;
      else if ($urandom_range(0, 5) == 0) c.velocity = '0;
    end
    return c;
  endfunction

  // Drive one command beat, with an occasional gap before it
  task automatic send_cmd(input voice_cmd_t c);
    if (!calm && $urandom_range(0, 3) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.cmd          <= c.cmd;
    cmd_if.note         <= c.note;
    cmd_if.velocity     <= c.velocity;
    cmd_if.load_address <= c.addr;
    cmd_if.left_in      <= c.left;
    cmd_if.right_in     <= c.right;
    do @(posedge clk_i); while (!cmd_if.ready);
    mirror.accept_command(c);
    n_cmds++;
    if (c.cmd == CMD_TICK) n_ticks++;
    if (c.cmd == CMD_LOAD) begin
      n_loads++;
      loaded[c.addr] = 1'b1;
    end
  endtask

  // Hold off commands until every result has come back
  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (mirror.results_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk_i);
    mirror.cfg_write(idx, v);
  endtask

  // New setting once every result is back, then make sure every word it can play is loaded
  task automatic apply_setup(input voice_setup_t s);
    int unsigned len, a;
    drain();
    write_reg(CFG_MODE,      17'(s.mode));
    write_reg(CFG_TRIG_NOTE, 17'(s.trig));
    write_reg(CFG_OFFSET,    17'(s.offset));
    write_reg(CFG_LENGTH,    s.len);
    write_reg(CFG_FADE_IN,   17'(s.fin));
    write_reg(CFG_FADE_OUT,  17'(s.fout));
    write_reg(CFG_FADE_LEN,  s.flen);
    write_reg(CFG_GAIN,      17'(s.gain));
    cfg_we <= 1'b0;
    n_setups++;
    len = mirror.eff_len();
    for (a = mirror.start_pos(len); a < len; a++) begin
      if (!loaded[a]) send_cmd(load_cmd(16'(a), 16'($urandom), 16'($urandom)));
    end
  endtask

  function automatic voice_setup_t setup(logic [2:0] m, logic [7:0] t, logic [15:0] o,
                                         logic [16:0] l, logic [15:0] fi, logic [15:0] fo,
                                         logic [16:0] fl, logic [15:0] g);
    voice_setup_t s;
    s.mode = m; s.trig = t; s.offset = o; s.len = l;
    s.fin = fi; s.fout = fo; s.flen = fl; s.gain = g;
    return s;
  endfunction

  task automatic run_random(input int unsigned n);
    repeat (n) send_cmd(rand_cmd());
  endtask

  // Main sequence
  initial begin
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= '0;
    cfg_data            <= '0;
    cmd_if.valid        <= 1'b0;
    cmd_if.cmd          <= CMD_NOP;
    cmd_if.note         <= '0;
    cmd_if.velocity     <= '0;
    cmd_if.load_address <= '0;
    cmd_if.left_in      <= '0;
    cmd_if.right_in     <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset setting has an empty sample: everything but a load keeps the voice idle
    send_cmd(mk_cmd(CMD_TRIGGER, 7'd0, 7'd0));
    send_cmd(mk_cmd(CMD_NOTE_ON, 7'd127, 7'd100));
    send_cmd(mk_cmd(CMD_TICK, 7'd0, 7'd0));
    send_cmd(mk_cmd(CMD_FADE, 7'd0, 7'd0));
    send_cmd(mk_cmd(CMD_NOTE_OFF, 7'd127, 7'd0));
    send_cmd(mk_cmd(CMD_HALT, 7'd0, 7'd0));
    send_cmd(mk_cmd(CMD_NOP, 7'd0, 7'd0));
    send_cmd(load_cmd(16'd0, 16'h8000, 16'h7FFF));
    send_cmd(load_cmd(16'd1, 16'h8000, 16'h7FFF));
    send_cmd(load_cmd(16'd65535, 16'h7FFF, 16'h8000));
    send_cmd(load_cmd(16'd65534, 16'hFFFF, 16'h0001));

    // Looping two-word sample, offset past the end, fade-in jump, zero fade-out step
    apply_setup(setup(3'd7, 8'd60, 16'd65535, 17'd2, 16'd40000, 16'd0, 17'd65536, 16'd65535));
    send_cmd(mk_cmd(CMD_NOTE_ON, 7'd61, 7'd100));
    send_cmd(mk_cmd(CMD_NOTE_ON, 7'd60, 7'd0));
    send_cmd(mk_cmd(CMD_NOTE_ON, 7'd60, 7'd127));
    send_cmd(mk_cmd(CMD_TICK, 7'd0, 7'd0));
    send_cmd(mk_cmd(CMD_TICK, 7'd0, 7'd0));
    send_cmd(mk_cmd(CMD_NOTE_ON, 7'd60, 7'd90));
    send_cmd(mk_cmd(CMD_TICK, 7'd0, 7'd0));
    send_cmd(mk_cmd(CMD_NOTE_OFF, 7'd59, 7'd0));
    send_cmd(mk_cmd(CMD_NOTE_OFF, 7'd60, 7'd0));
    send_cmd(mk_cmd(CMD_TICK, 7'd0, 7'd0));
    send_cmd(mk_cmd(CMD_HALT, 7'd0, 7'd0));
    send_cmd(mk_cmd(CMD_TICK, 7'd0, 7'd0));

    // Full-depth length, played from the last words up to the end of the store
    apply_setup(setup(3'd0, 8'd255, 16'd65534, 17'd65536, 16'd16384, 16'd32768, 17'd1,
                      16'd16384));
    send_cmd(mk_cmd(CMD_NOTE_ON, 7'd5, 7'd1));
    send_cmd(mk_cmd(CMD_TICK, 7'd0, 7'd0));
    send_cmd(mk_cmd(CMD_TICK, 7'd0, 7'd0));
    send_cmd(mk_cmd(CMD_TICK, 7'd0, 7'd0));

    // Random phases over a spread of settings
    apply_setup(setup(3'd4, 8'd128, 16'd0, 17'd16, 16'd4096, 16'd4096, 17'd4, 16'd16384));
    run_random(60);
    apply_setup(setup(3'd1, 8'd60, 16'd3, 17'd24, 16'd1000, 16'd3000, 17'd8, 16'd30000));
    run_random(60);
    apply_setup(setup(3'd2, 8'd128, 16'd5, 17'd32, 16'd32768, 16'd32768, 17'd1, 16'd65535));
    run_random(60);
    apply_setup(setup(3'd6, 8'd200, 16'd100, 17'd20, 16'd0, 16'd0, 17'd65536, 16'd8000));
    run_random(60);
    apply_setup(setup(3'd5, 8'd0, 16'd10, 17'd0, 16'd228, 16'd85, 17'd384, 16'd16384));
    run_random(20);
    apply_setup(setup(3'd3, 8'd64, 16'd0, 17'd40, 16'd65535, 16'd1, 17'd10, 16'd0));
    run_random(60);
    apply_setup(setup(3'd5, 8'd0, 16'd10, 17'd12, 16'd228, 16'd85, 17'd384, 16'd16384));
    run_random(60);
    apply_setup(setup(3'd7, 8'd127, 16'd2, 17'd48, 16'd5000, 16'd700, 17'd6, 16'd40000));
    run_random(60);
    // last stretch runs without idling on either side
    calm = 1'b1;
    apply_setup(setup(3'd0, 8'd128, 16'd0, 17'd64, 16'd2048, 16'd2048, 17'd12, 16'd20000));
    run_random(60);

    drain();
    repeat (16) @(posedge clk_i);
    $display("covered %0d commands (%0d ticks, %0d loads) over %0d register settings",
             n_cmds, n_ticks, n_loads, n_setups);
    $display("checked %0d result beats, %0d errors", mirror.checked, mirror.errors);
    if (mirror.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ triggered_sample_voice_core.f @@
rtl/tsv_pkg.sv
rtl/tsv_if.sv
rtl/tsv_store.sv
rtl/tsv_mul.sv
rtl/triggered_sample_voice_core.sv
sim/tb_top.sv
